@@ hdl/assert_macros.svh @@
// assertion helpers shared by the sdf csg combine rtl
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define CHECK_HOLDS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// consequent must hold whenever the antecedent does
`define CHECK_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

@@ hdl/sdfc_pkg.sv @@
// shared types and constants for the sdf csg combine block
// no dependencies; imported by the interfaces and every module
`default_nettype none

package sdfc_pkg;

    localparam int KIND_W   = 3;
    localparam int DIST_W   = 32;
    localparam int RADIUS_W = 31;
    // b - a, b + a and their negations need 34 bits
    localparam int NUM_W    = 34;
    // hard result can be minus the most negative distance
    localparam int HARD_W   = 33;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNION            = 3'd0,
        KIND_INTERSECT        = 3'd1,
        KIND_SUBTRACT         = 3'd2,
        KIND_SMOOTH_UNION     = 3'd3,
        KIND_SMOOTH_SUBTRACT  = 3'd4,
        KIND_SMOOTH_INTERSECT = 3'd5
    } t_kind;

    // one item as it moves down the pipeline
    typedef struct packed {
        logic                     smooth;   // take the blended result
        logic                     mirror;   // h = half - q and bump is added
        logic signed [NUM_W-1:0]  num;      // numerator of the blend quotient
        logic signed [NUM_W-1:0]  d;        // factor scaled by h
        logic signed [DIST_W-1:0] b;
        logic signed [HARD_W-1:0] hard;     // min or max result, unsaturated
    } t_item;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     saturated;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/sdfc_if.sv @@
// stream interfaces for the operand and result channels
// depends on sdfc_pkg for field widths
`default_nettype none

interface sdfc_in_if;
    import sdfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DIST_W-1:0] distance_a;
    logic signed [DIST_W-1:0] distance_b;

    modport source (output valid, kind, distance_a, distance_b, input ready);
    modport sink   (input valid, kind, distance_a, distance_b, output ready);
endinterface

interface sdfc_out_if;
    import sdfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance_out;
    logic                     saturated;

    modport source (output valid, distance_out, saturated, input ready);
    modport sink   (input valid, distance_out, saturated, output ready);
endinterface

`default_nettype wire

@@ hdl/sdfc_front.sv @@
// first pipeline stage: kind decode, hard min/max and blend operands
// depends on sdfc_pkg
`default_nettype none

module sdfc_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire logic [sdfc_pkg::KIND_W-1:0]      i_kind,
    input  wire logic signed [sdfc_pkg::DIST_W-1:0] i_distance_a,
    input  wire logic signed [sdfc_pkg::DIST_W-1:0] i_distance_b,
    output logic                                  o_valid,
    output sdfc_pkg::t_item                       o_item
);
    import sdfc_pkg::*;

    logic                     r_valid;
    t_item                    r_item;
    t_item                    n_item;
    logic signed [NUM_W-1:0]  a_x;
    logic signed [NUM_W-1:0]  b_x;
    logic signed [HARD_W-1:0] a_h;
    logic signed [HARD_W-1:0] b_h;
    logic signed [HARD_W-1:0] nb_h;
    logic signed [HARD_W-1:0] min_ab;
    logic signed [HARD_W-1:0] max_ab;
    logic signed [HARD_W-1:0] max_anb;

    // operand widening and the candidate hard results
    always_comb begin
        a_x     = NUM_W'(i_distance_a);
        b_x     = NUM_W'(i_distance_b);
        a_h     = HARD_W'(i_distance_a);
        b_h     = HARD_W'(i_distance_b);
        nb_h    = -b_h;
        min_ab  = (a_h < b_h) ? a_h : b_h;
        max_ab  = (a_h > b_h) ? a_h : b_h;
        max_anb = (a_h > nb_h) ? a_h : nb_h;
    end

    // kind decode; unused codes act as union
    always_comb begin
        n_item.smooth = 1'b0;
        n_item.mirror = 1'b0;
        n_item.num    = b_x - a_x;
        n_item.d      = a_x - b_x;
        n_item.b      = i_distance_b;
        n_item.hard   = min_ab;
        unique case (t_kind'(i_kind))
            KIND_INTERSECT: begin
                n_item.hard = max_ab;
            end
            KIND_SUBTRACT: begin
                n_item.hard = max_anb;
            end
            KIND_SMOOTH_UNION: begin
                n_item.smooth = 1'b1;
            end
            KIND_SMOOTH_SUBTRACT: begin
                n_item.smooth = 1'b1;
                n_item.mirror = 1'b1;
                n_item.num    = b_x + a_x;
                n_item.d      = -a_x - b_x;
            end
            KIND_SMOOTH_INTERSECT: begin
                n_item.smooth = 1'b1;
                n_item.mirror = 1'b1;
            end
            default: begin
                n_item.hard = min_ab;
            end
        endcase
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hdl/sdfc_div.sv @@
// blend weight h: pipelined restoring divider, one quotient bit per stage
// depends on sdfc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdfc_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire sdfc_pkg::t_item                   i_item,
    input  wire logic [sdfc_pkg::RADIUS_W-1:0]     i_radius,
    output logic                                   o_valid,
    output sdfc_pkg::t_item                        o_item,
    output logic [FRAC_BITS:0]                     o_h
);
    import sdfc_pkg::*;

    localparam int STEPS = FRAC_BITS - 1;
    localparam int Q_W   = FRAC_BITS - 1;
    localparam int H_W   = FRAC_BITS + 1;
    localparam int ABS_W = NUM_W - 1;
    localparam int REM_W = RADIUS_W;
    localparam logic [H_W-1:0] HALF = {1'b0, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [H_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};

    // magnitude stage
    logic             r_a_v;
    t_item            r_a_item;
    logic [ABS_W-1:0] r_a_abs;
    logic             r_a_sgn;
    logic [ABS_W-1:0] n_a_abs;
    logic             n_a_sgn;

    // quotient stages; entry 0 holds the range check
    logic [STEPS:0]   r_v;
    logic [REM_W-1:0] r_rem [0:STEPS];
    logic [Q_W-1:0]   r_quo [0:STEPS];
    logic             r_ovf [0:STEPS];
    logic             r_sgn [0:STEPS];
    t_item            r_item [0:STEPS];
    logic [REM_W-1:0] n_rem [0:STEPS];
    logic [Q_W-1:0]   n_quo [0:STEPS];
    logic             n_ovf;

    // weight stage
    logic             r_h_v;
    t_item            r_h_item;
    logic [H_W-1:0]   r_h;
    logic [H_W-1:0]   n_h;
    logic [H_W-1:0]   q_sat;

    // magnitude of the numerator and the direction of q around half
    always_comb begin
        n_a_abs = i_item.num[NUM_W-1] ? ABS_W'(-i_item.num) : ABS_W'(i_item.num);
        n_a_sgn = i_item.num[NUM_W-1] ^ i_item.mirror;
    end

    // range check, then one restoring step per stage
    always_comb begin
        logic [REM_W:0] rem2;
        logic           ge;
        rem2     = '0;
        ge       = 1'b0;
        // |num| >= k means |q| >= half, so h lands on 0 or one
        n_ovf    = r_a_abs >= ABS_W'(i_radius);
        n_rem[0] = n_ovf ? '0 : r_a_abs[REM_W-1:0];
        n_quo[0] = '0;
        for (int j = 1; j <= STEPS; j++) begin
            rem2     = {r_rem[j-1], 1'b0};
            ge       = rem2 >= {1'b0, i_radius};
            n_rem[j] = ge ? REM_W'(rem2 - {1'b0, i_radius}) : REM_W'(rem2);
            n_quo[j] = {r_quo[j-1][Q_W-2:0], ge};
        end
    end

    // h = half +/- min(|q|, half), already inside 0..one
    always_comb begin
        q_sat = r_ovf[STEPS] ? HALF : H_W'(r_quo[STEPS]);
        n_h   = r_sgn[STEPS] ? (HALF - q_sat) : (HALF + q_sat);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_v   <= '0;
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_v   <= {r_v[STEPS-1:0], r_a_v};
            r_h_v <= r_v[STEPS];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item  <= i_item;
            r_a_abs   <= n_a_abs;
            r_a_sgn   <= n_a_sgn;
            r_item[0] <= r_a_item;
            r_ovf[0]  <= n_ovf;
            r_sgn[0]  <= r_a_sgn;
            r_rem[0]  <= n_rem[0];
            r_quo[0]  <= n_quo[0];
            for (int j = 1; j <= STEPS; j++) begin
                r_item[j] <= r_item[j-1];
                r_ovf[j]  <= r_ovf[j-1];
                r_sgn[j]  <= r_sgn[j-1];
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
            end
            r_h_item  <= r_item[STEPS];
            r_h       <= n_h;
        end
    end

    assign o_valid = r_h_v;
    assign o_item  = r_h_item;
    assign o_h     = r_h;

    `CHECK_IMPLIES(a_h_in_range, i_clk, i_rst_n, r_h_v, r_h <= ONE)
    `CHECK_IMPLIES(a_rem_below_radius, i_clk, i_rst_n, r_v[STEPS], r_rem[STEPS] < i_radius)

endmodule

`default_nettype wire

@@ hdl/sdfc_blend.sv @@
// polynomial blend: scaled difference, bump term, final sum and saturation
// depends on sdfc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdfc_blend #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire sdfc_pkg::t_item               i_item,
    input  wire logic [FRAC_BITS:0]            i_h,
    input  wire logic [sdfc_pkg::RADIUS_W-1:0] i_radius,
    output logic                               o_valid,
    output sdfc_pkg::t_result                  o_result
);
    import sdfc_pkg::*;

    localparam int H_W   = FRAC_BITS + 1;
    localparam int P1_W  = NUM_W + H_W + 1;
    localparam int P1R_W = P1_W - FRAC_BITS;
    localparam int KH_W  = RADIUS_W + H_W;
    localparam int SUM_W = NUM_W + 3;
    localparam int STAGES = 6;
    localparam logic [H_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [P1_W-1:0] P1_HALF =
        {{(P1_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [KH_W-1:0] KH_HALF =
        {{(KH_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic [STAGES-1:0] r_v;

    // stage 1: products with h, and one minus h
    t_item                    r1_item;
    logic signed [P1_W-1:0]   r1_p1;
    logic [KH_W-1:0]          r1_kh;
    logic [H_W-1:0]           r1_omh;
    logic signed [P1_W-1:0]   n1_p1;
    logic [KH_W-1:0]          n1_kh;
    logic [H_W-1:0]           n1_omh;

    // stage 2: rounding
    t_item                    r2_item;
    logic signed [P1R_W-1:0]  r2_p1r;
    logic [RADIUS_W-1:0]      r2_kh;
    logic [H_W-1:0]           r2_omh;
    logic signed [P1R_W-1:0]  n2_p1r;
    logic [RADIUS_W-1:0]      n2_kh;

    // stage 3: bump product
    t_item                    r3_item;
    logic signed [P1R_W-1:0]  r3_p1r;
    logic [KH_W-1:0]          r3_bump_raw;
    logic [KH_W-1:0]          n3_bump_raw;

    // stage 4: bump rounding and base sum
    t_item                    r4_item;
    logic [RADIUS_W-1:0]      r4_bump;
    logic signed [SUM_W-1:0]  r4_base;
    logic [RADIUS_W-1:0]      n4_bump;
    logic signed [SUM_W-1:0]  n4_base;

    // stage 5: bump applied, smooth or hard selected
    logic signed [SUM_W-1:0]  r5_res;
    logic signed [SUM_W-1:0]  n5_res;
    logic signed [SUM_W-1:0]  bump_s;
    logic signed [SUM_W-1:0]  sum;

    // stage 6: saturation
    t_result                  r6_result;
    t_result                  n6_result;

    always_comb begin
        n1_p1  = i_item.d * $signed({1'b0, i_h});
        n1_kh  = KH_W'(i_radius) * KH_W'(i_h);
        n1_omh = ONE - i_h;
    end

    // round to nearest, ties up, via floor of value plus half
    always_comb begin
        n2_p1r = P1R_W'((r1_p1 + P1_HALF) >>> FRAC_BITS);
        n2_kh  = RADIUS_W'((r1_kh + KH_HALF) >> FRAC_BITS);
    end

    always_comb begin
        n3_bump_raw = KH_W'(r2_kh) * KH_W'(r2_omh);
    end

    always_comb begin
        n4_bump = RADIUS_W'((r3_bump_raw + KH_HALF) >> FRAC_BITS);
        n4_base = SUM_W'(r3_item.b) + SUM_W'(r3_p1r);
    end

    // union subtracts the bump, subtract and intersect add it
    always_comb begin
        bump_s = $signed({{(SUM_W-RADIUS_W){1'b0}}, r4_bump});
        sum    = r4_item.mirror ? (r4_base + bump_s) : (r4_base - bump_s);
        n5_res = r4_item.smooth ? sum : SUM_W'(r4_item.hard);
    end

    // clamp to 32 bits and flag it
    always_comb begin
        if (r5_res > SUM_W'(DIST_MAX)) begin
            n6_result.distance  = DIST_MAX;
            n6_result.saturated = 1'b1;
        end else if (r5_res < SUM_W'(DIST_MIN)) begin
            n6_result.distance  = DIST_MIN;
            n6_result.saturated = 1'b1;
        end else begin
            n6_result.distance  = DIST_W'(r5_res);
            n6_result.saturated = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item     <= i_item;
            r1_p1       <= n1_p1;
            r1_kh       <= n1_kh;
            r1_omh      <= n1_omh;
            r2_item     <= r1_item;
            r2_p1r      <= n2_p1r;
            r2_kh       <= n2_kh;
            r2_omh      <= r1_omh;
            r3_item     <= r2_item;
            r3_p1r      <= r2_p1r;
            r3_bump_raw <= n3_bump_raw;
            r4_item     <= r3_item;
            r4_bump     <= n4_bump;
            r4_base     <= n4_base;
            r5_res      <= n5_res;
            r6_result   <= n6_result;
        end
    end

    assign o_valid  = r_v[STAGES-1];
    assign o_result = r6_result;

    `CHECK_IMPLIES(a_sat_at_limit, i_clk, i_rst_n, r_v[STAGES-1] && r6_result.saturated, r6_result.distance == DIST_MAX || r6_result.distance == DIST_MIN)
    `CHECK_IMPLIES(a_bump_bounded, i_clk, i_rst_n, r_v[3], r4_bump <= i_radius)

endmodule

`default_nettype wire

@@ hdl/sdf_csg_combine.sv @@
// top level of the sdf csg combine block: radius register, pipeline, output skid
// depends on sdfc_pkg, sdfc_if, sdfc_front, sdfc_div, sdfc_blend, assert_macros.svh
//
//   port        dir   carries
//   i_in        sink  kind, distance_a, distance_b (one beat per item)
//   o_out       src   distance_out, saturated (one beat per item)
//   i_cfg_*     in    smooth_radius write, no read-back
//
// one beat per cycle sustained while the skid register stays empty; the divider
// resolves one quotient bit per stage
// reset clears all valid bits and sets the radius to 1.0
// a beat leaving the pipeline behind a stalled output beat goes to the skid
// register; input ready drops only while the skid register is full, and the
// whole pipeline holds then
`default_nettype none
`include "assert_macros.svh"

module sdf_csg_combine #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sdfc_in_if.sink                            i_in,
    sdfc_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [sdfc_pkg::RADIUS_W-1:0] i_cfg_wdata
);
    import sdfc_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    logic [RADIUS_W-1:0] n_radius;
    logic                en;

    logic                front_valid;
    t_item               front_item;
    logic                div_valid;
    t_item               div_item;
    logic [FRAC_BITS:0]  div_h;
    logic                pipe_valid;
    t_result             pipe_result;

    logic                r_out_valid;
    t_result             r_out_data;
    logic                r_skid_valid;
    t_result             r_skid_data;
    logic                n_out_valid;
    logic                n_skid_valid;
    logic                load_out;
    logic                load_skid;
    t_result             n_out_data;

    // radius register; zero is stored as the smallest radius
    always_comb begin
        n_radius = (i_cfg_wdata == '0) ? RADIUS_W'(1) : i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= n_radius;
        end
    end

    // whole pipeline advances while the skid register is empty
    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    sdfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in.valid),
        .i_kind       (i_in.kind),
        .i_distance_a (i_in.distance_a),
        .i_distance_b (i_in.distance_b),
        .o_valid      (front_valid),
        .o_item       (front_item)
    );

    sdfc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (front_valid),
        .i_item   (front_item),
        .i_radius (r_radius),
        .o_valid  (div_valid),
        .o_item   (div_item),
        .o_h      (div_h)
    );

    sdfc_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (div_valid),
        .i_item   (div_item),
        .i_h      (div_h),
        .i_radius (r_radius),
        .o_valid  (pipe_valid),
        .o_result (pipe_result)
    );

    // output register with skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        load_out     = 1'b0;
        load_skid    = 1'b0;
        n_out_data   = r_skid_valid ? r_skid_data : pipe_result;
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
                load_out     = 1'b1;
            end else begin
                n_out_valid = pipe_valid;
                load_out    = pipe_valid;
            end
        end else if (pipe_valid && en) begin
            n_skid_valid = 1'b1;
            load_skid    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
        end
        if (load_skid) begin
            r_skid_data <= pipe_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.distance_out = r_out_data.distance;
    assign o_out.saturated    = r_out_data.saturated;

    `CHECK_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CHECK_HOLDS(a_radius_nonzero, i_clk, i_rst_n, r_radius != '0)
    `CHECK_IMPLIES(a_skid_drains, i_clk, i_rst_n, r_skid_valid && o_out.ready, !n_skid_valid)

endmodule

`default_nettype wire

@@ bench/sdfc_combine_checker.sv @@
// scoreboard for the sdf csg combine block: predicts each combined distance and compares
// depends on sdfc_pkg for widths and kind codes, and on sdfc_if for the watched channels
`default_nettype none

module sdfc_combine_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sdfc_in_if                                 i_in,
    sdfc_out_if                                i_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [sdfc_pkg::RADIUS_W-1:0] i_cfg_wdata,
    output int                                 o_mismatches,
    output int                                 o_outstanding
);
    import sdfc_pkg::*;

    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);
    localparam longint ONE  = longint'(1) << FRAC_BITS;

    logic [RADIUS_W-1:0] radius;
    t_result             expected_combines[$];
    int                  fails = 0;

    assign o_mismatches = fails;

    // rescale by one, rounding to nearest with ties going up
    function automatic longint rescale(input longint x);
        return (x + HALF) >>> FRAC_BITS;
    endfunction

    // blend weight h, clamped to 0..one; quotient truncates toward zero
    function automatic longint blend_weight(input longint num, input longint k, input bit mirror);
        longint q;
        longint h;
        q = (num * HALF) / k;
        h = mirror ? HALF - q : HALF + q;
        if (h < 0) h = 0;
        if (h > ONE) h = ONE;
        return h;
    endfunction

    // k*h*(1-h), rounded after each product
    function automatic longint bump(input longint k, input longint h);
        return rescale(rescale(k * h) * (ONE - h));
    endfunction

    function automatic t_result predict_combine(
        input logic [KIND_W-1:0]        kind,
        input logic signed [DIST_W-1:0] da,
        input logic signed [DIST_W-1:0] db,
        input logic [RADIUS_W-1:0]      radius_q
    );
        longint  a;
        longint  b;
        longint  k;
        longint  h;
        longint  r;
        t_result res;
        a = longint'(da);
        b = longint'(db);
        k = longint'(radius_q);
        // a zero radius acts as one lsb
        if (k == 0) k = 1;
        case (kind)
            KIND_INTERSECT: r = (a > b) ? a : b;
            KIND_SUBTRACT:  r = (a > -b) ? a : -b;
            KIND_SMOOTH_UNION: begin
                h = blend_weight(b - a, k, 1'b0);
                r = b + rescale((a - b) * h) - bump(k, h);
            end
            KIND_SMOOTH_SUBTRACT: begin
                h = blend_weight(b + a, k, 1'b1);
                r = b + rescale((-a - b) * h) + bump(k, h);
            end
            KIND_SMOOTH_INTERSECT: begin
                h = blend_weight(b - a, k, 1'b1);
                r = b + rescale((a - b) * h) + bump(k, h);
            end
            // union, and the unused kinds
            default: r = (a < b) ? a : b;
        endcase
        res.saturated = 1'b0;
        if (r > longint'(DIST_MAX)) begin
            r = longint'(DIST_MAX);
            res.saturated = 1'b1;
        end else if (r < longint'(DIST_MIN)) begin
            r = longint'(DIST_MIN);
            res.saturated = 1'b1;
        end
        res.distance = r[DIST_W-1:0];
        return res;
    endfunction

    // track the radius, queue a prediction per input beat, check each output beat
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            radius <= RADIUS_RESET;
            expected_combines.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we) begin
                radius <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                expected_combines.push_back(predict_combine(i_in.kind, i_in.distance_a,
                                                            i_in.distance_b, radius));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_combines.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected result beat: distance %h saturated %b",
                                 i_out.distance_out, i_out.saturated);
                    end
                    fails++;
                end else begin
                    want = expected_combines.pop_front();
                    if (i_out.distance_out !== want.distance
                        || i_out.saturated !== want.saturated) begin
                        if (fails < 10) begin
                            $display("mismatch: expected distance %h saturated %b, got %h %b",
                                     want.distance, want.saturated,
                                     i_out.distance_out, i_out.saturated);
                        end
                        fails++;
                    end
                end
            end
            o_outstanding <= expected_combines.size();
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_sdf_csg_combine.sv @@
// top of the sdf csg combine testbench: clock, reset, stimulus, radius writes and verdict
// depends on sdfc_pkg, sdfc_if, sdf_csg_combine and sdfc_combine_checker
`default_nettype none

module tb_sdf_csg_combine;
    import sdfc_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int LATENCY       = FRAC_BITS + 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int BEATS_PER_SET = 135;
    localparam int NUM_SETS      = 8;
    localparam int MODE_SPAN     = (BEATS_PER_SET * NUM_SETS) / 3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                rx_ready = 1'b0;
    logic                cfg_we;
    logic [RADIUS_W-1:0] cfg_wdata;
    int                  mismatches;
    int                  outstanding;
    int                  send_idle = 25;
    int                  recv_idle = 63;
    int                  stall_cycles = 0;
    longint              cur_radius = longint'(RADIUS_RESET);

    sdfc_in_if  in_ch ();
    sdfc_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    sdf_csg_combine #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    sdfc_combine_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 12 unit clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side backpressure
    always @(posedge clk) begin
        rx_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one operand beat, with random gaps, and hold it until taken
    task automatic send_beat(input logic [KIND_W-1:0] kind,
                             input logic signed [DIST_W-1:0] a,
                             input logic signed [DIST_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.distance_a <= a;
        in_ch.distance_b <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // stop sending and let every queued result come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // operand mix: extremes, values near zero, anything
    function automatic logic signed [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 7))
            0:       return DIST_MAX - $urandom_range(0, 3);
            1:       return DIST_MIN + $urandom_range(0, 3);
            2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom();
        endcase
    endfunction

    // second operand mostly within 2*radius+1 of the first (of minus the first for smooth subtract)
    function automatic logic signed [DIST_W-1:0] pick_partner(
        input logic [KIND_W-1:0] kind, input logic signed [DIST_W-1:0] a);
        longint centre;
        longint delta;
        if ($urandom_range(0, 3) == 0) return pick_distance();
        centre = (kind == KIND_SMOOTH_SUBTRACT) ? -longint'(a) : longint'(a);
        delta  = longint'($urandom()) % (2 * cur_radius + 2);
        if ($urandom_range(0, 1) == 1) delta = -delta;
        return 32'(centre + delta);
    endfunction

    initial begin : stimulus
        logic [RADIUS_W-1:0]      radius_set[NUM_SETS];
        logic [KIND_W-1:0]        kind;
        logic signed [DIST_W-1:0] a;
        int                       sel;
        int                       beat_no;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_UNION;
        in_ch.distance_a <= '0;
        in_ch.distance_b <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats at the reset radius of 1.0
        send_beat(KIND_UNION, DIST_MIN, DIST_MAX);
        send_beat(KIND_UNION, DIST_MAX, DIST_MIN);
        send_beat(KIND_UNION, 32'sd0, 32'sd0);
        send_beat(KIND_INTERSECT, DIST_MIN, DIST_MAX);
        send_beat(KIND_INTERSECT, 32'sd0, -32'sd1);
        // minus the most negative distance saturates
        send_beat(KIND_SUBTRACT, 32'sd0, DIST_MIN);
        send_beat(KIND_SUBTRACT, DIST_MIN, DIST_MAX);
        send_beat(KIND_SUBTRACT, 32'sd5, 32'sd3);
        send_beat(KIND_SMOOTH_UNION, 32'sd0, 32'sd0);
        send_beat(KIND_SMOOTH_UNION, DIST_MIN, DIST_MIN);
        send_beat(KIND_SMOOTH_UNION, DIST_MAX, DIST_MAX);
        // blend weight clamped high, then low, then mid band
        send_beat(KIND_SMOOTH_UNION, 32'sd0, 32'sh0002_0000);
        send_beat(KIND_SMOOTH_UNION, 32'sh0002_0000, 32'sd0);
        send_beat(KIND_SMOOTH_UNION, 32'sh0000_8000, 32'sd0);
        send_beat(KIND_SMOOTH_SUBTRACT, DIST_MIN, DIST_MIN);
        send_beat(KIND_SMOOTH_SUBTRACT, DIST_MAX, DIST_MAX);
        send_beat(KIND_SMOOTH_SUBTRACT, 32'sh0001_0000, -32'sh0001_0000);
        send_beat(KIND_SMOOTH_SUBTRACT, 32'sh0000_4000, 32'sh0000_1000);
        send_beat(KIND_SMOOTH_INTERSECT, DIST_MAX, DIST_MAX);
        send_beat(KIND_SMOOTH_INTERSECT, DIST_MIN, DIST_MAX);
        send_beat(KIND_SMOOTH_INTERSECT, 32'sh0000_3000, -32'sh0000_2000);
        // unused kinds behave as union
        send_beat(3'd6, 32'sd1, 32'sd2);
        send_beat(3'd7, DIST_MAX, -32'sd1);

        // radius settings, extremes and zero among them
        radius_set[0] = 31'd1;
        radius_set[1] = 31'd0;
        radius_set[2] = 31'h7FFF_FFFF;
        radius_set[3] = 31'd3;
        radius_set[4] = 31'h0004_0000;
        radius_set[5] = RADIUS_W'($urandom_range(1, 32'h00FF_FFFF));
        radius_set[6] = 31'h0000_0100;
        radius_set[7] = RADIUS_RESET;

        beat_no = 0;
        for (int s = 0; s < NUM_SETS; s++) begin
            wait_drained();
            cfg_we    <= 1'b1;
            cfg_wdata <= radius_set[s];
            @(posedge clk);
            cfg_we     <= 1'b0;
            cur_radius = longint'(radius_set[s]);
            for (int n = 0; n < BEATS_PER_SET; n++) begin
                // idling: sender light then heavy, receiver heavy then light, then none at all
                if (beat_no < MODE_SPAN) begin
                    send_idle = 25;
                    recv_idle = 63;
                end else if (beat_no < 2 * MODE_SPAN) begin
                    send_idle = 63;
                    recv_idle = 25;
                end else begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                sel  = $urandom_range(0, 19);
                kind = (sel < 18) ? KIND_W'(sel % 6) : KIND_W'(sel - 12);
                a    = pick_distance();
                send_beat(kind, a, pick_partner(kind, a));
                beat_no++;
            end
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sdf_csg_combine.f @@
+incdir+hdl
hdl/sdfc_pkg.sv
hdl/sdfc_if.sv
hdl/sdfc_front.sv
hdl/sdfc_div.sv
hdl/sdfc_blend.sv
hdl/sdf_csg_combine.sv
bench/sdfc_combine_checker.sv
bench/tb_sdf_csg_combine.sv
